[src/qmi_pkg.sv]
// Shared constants, transfer types, op format and ring index helpers for the middle-insert queue.
`default_nettype none

package qmi_pkg;

  // Storage size: entries per half ring and total queue capacity.
  localparam int DEPTH = 1024;
  localparam int AW    = $clog2(DEPTH);      // ring index
  localparam int CW    = $clog2(DEPTH + 1);  // per-half count
  localparam int NW    = CW + 1;             // total length, front plus back

  localparam int CMDW = 2;
  localparam int VALW = 32;
  localparam int STW  = 2;
  localparam int LENW = 11;

  // Commands. The high command bit selects pop, so code three pops as well.
  localparam logic [CMDW-1:0] CMD_PUSH_TAIL = 2'd0;
  localparam logic [CMDW-1:0] CMD_PUSH_MID  = 2'd1;
  localparam logic [CMDW-1:0] CMD_POP       = 2'd2;
  localparam logic [CMDW-1:0] CMD_POP_ALT   = 2'd3;

  // Result status codes.
  localparam logic [STW-1:0] ST_PUSHED = 2'd0;
  localparam logic [STW-1:0] ST_POPPED = 2'd1;
  localparam logic [STW-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STW-1:0] ST_FULL   = 2'd3;

  // Op queue between classifier and executor.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CMDW-1:0]        command;
    logic signed [VALW-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [STW-1:0]         status;
    logic signed [VALW-1:0] popped_value;
    logic [LENW-1:0]        length;
  } out_item_t;

  // One classified item: the ring accesses it needs plus its precomputed result fields.
  typedef struct packed {
    logic [STW-1:0]  status;
    logic [LENW-1:0] length;
    logic [VALW-1:0] value;
    logic            f_wr;       // write value to front ring at f_wr_addr
    logic            b_wr;       // write value to back ring at b_wr_addr
    logic            move;       // read back ring at b_rd_addr, write it to front at f_wr_addr
    logic            pop;        // read front ring at f_rd_addr, report it
    logic [AW-1:0]   f_rd_addr;
    logic [AW-1:0]   f_wr_addr;
    logic [AW-1:0]   b_rd_addr;
    logic [AW-1:0]   b_wr_addr;
  } op_t;

  typedef enum logic {
    BK_ISSUE,
    BK_COMPLETE
  } bk_state_t;

  // start + count modulo DEPTH; the sum stays below twice DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [NW-1:0] s;
    s = NW'(a) + NW'(b);
    if (s >= NW'(DEPTH)) begin
      s = s - NW'(DEPTH);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

endpackage

`default_nettype wire

[src/qmi_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module qmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/qmi_front.sv]
// Front end: accepts items, keeps ring starts and counts, emits classified ops.
`default_nettype none

module qmi_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire qmi_pkg::in_item_t in_data,
  output logic                  q_push,
  output qmi_pkg::op_t          q_op,
  input  wire logic             q_full
);

  logic [qmi_pkg::AW-1:0] fs_r, fs_nxt, bs_r, bs_nxt;
  logic [qmi_pkg::CW-1:0] fc_r, fc_nxt, bc_r, bc_nxt;
  logic [qmi_pkg::NW-1:0] n;
  logic                   bal;
  logic                   is_pop;
  logic                   accept;
  logic [qmi_pkg::AW-1:0] f_tail, b_tail, b_head_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign n          = qmi_pkg::NW'(fc_r) + qmi_pkg::NW'(bc_r);
  assign bal        = (fc_r == bc_r);  // otherwise front holds one more
  assign f_tail     = qmi_pkg::wrap_add(fs_r, fc_r);
  assign b_tail     = qmi_pkg::wrap_add(bs_r, bc_r);
  assign b_head_dec = qmi_pkg::wrap_dec(bs_r);
  assign is_pop     = (in_data.command == qmi_pkg::CMD_POP) ||
                      (in_data.command == qmi_pkg::CMD_POP_ALT);

  always_comb begin
    fs_nxt = fs_r;
    bs_nxt = bs_r;
    fc_nxt = fc_r;
    bc_nxt = bc_r;

    q_op           = '0;
    q_op.value     = in_data.item_value;
    q_op.f_rd_addr = fs_r;
    q_op.f_wr_addr = f_tail;
    q_op.b_rd_addr = bs_r;
    q_op.b_wr_addr = b_tail;
    q_op.length    = qmi_pkg::LENW'(n);

    if (is_pop) begin
      if (n == '0) begin
        q_op.status = qmi_pkg::ST_EMPTY;
      end else begin
        q_op.status = qmi_pkg::ST_POPPED;
        q_op.pop    = 1'b1;
        q_op.length = qmi_pkg::LENW'(n - 1'b1);
        fs_nxt      = qmi_pkg::wrap_add(fs_r, qmi_pkg::CW'(1));
        if (bal) begin
          // back head refills the front tail; front count unchanged
          q_op.move = 1'b1;
          bs_nxt    = qmi_pkg::wrap_add(bs_r, qmi_pkg::CW'(1));
          bc_nxt    = bc_r - 1'b1;
        end else begin
          fc_nxt = fc_r - 1'b1;
        end
      end
    end else if (n >= qmi_pkg::NW'(qmi_pkg::DEPTH)) begin
      q_op.status = qmi_pkg::ST_FULL;
    end else begin
      q_op.status = qmi_pkg::ST_PUSHED;
      q_op.length = qmi_pkg::LENW'(n + 1'b1);
      if (in_data.command == qmi_pkg::CMD_PUSH_TAIL) begin
        if (n == '0) begin
          // lone entry ends up at the front
          q_op.f_wr = 1'b1;
          fc_nxt    = fc_r + 1'b1;
        end else if (bal) begin
          q_op.b_wr = 1'b1;
          q_op.move = 1'b1;
          bs_nxt    = qmi_pkg::wrap_add(bs_r, qmi_pkg::CW'(1));
          fc_nxt    = fc_r + 1'b1;
        end else begin
          q_op.b_wr = 1'b1;
          bc_nxt    = bc_r + 1'b1;
        end
      end else begin
        if (bal) begin
          q_op.f_wr = 1'b1;
          fc_nxt    = fc_r + 1'b1;
        end else begin
          // new value would move straight over: place it at the back head
          q_op.b_wr      = 1'b1;
          q_op.b_wr_addr = b_head_dec;
          bs_nxt         = b_head_dec;
          bc_nxt         = bc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= '0;
      bs_r <= '0;
      fc_r <= '0;
      bc_r <= '0;
    end else if (accept) begin
      fs_r <= fs_nxt;
      bs_r <= bs_nxt;
      fc_r <= fc_nxt;
      bc_r <= bc_nxt;
    end
  end

endmodule

`default_nettype wire

[src/qmi_fifo.sv]
// Short register queue of classified ops between front and back.
`default_nettype none

module qmi_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire qmi_pkg::op_t push_op,
  output logic              full,
  input  wire logic         pop,
  output logic              valid,
  output qmi_pkg::op_t      head
);

  qmi_pkg::op_t            mem_r [qmi_pkg::QDEPTH];
  logic [qmi_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [qmi_pkg::QCW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == qmi_pkg::QCW'(qmi_pkg::QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == qmi_pkg::QAW'(qmi_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == qmi_pkg::QAW'(qmi_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

[src/qmi_back.sv]
// Back end: runs each op against the two half rings and registers the result.
`default_nettype none

module qmi_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               op_valid,
  input  wire qmi_pkg::op_t       op,
  output logic                    op_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qmi_pkg::out_item_t      out_data
);

  qmi_pkg::bk_state_t state_r, state_nxt;
  qmi_pkg::op_t       op_r;
  qmi_pkg::out_item_t out_data_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               done;

  logic                     f_wr_en, f_rd_en, b_wr_en, b_rd_en;
  logic [qmi_pkg::AW-1:0]   f_wr_addr;
  logic [qmi_pkg::VALW-1:0] f_wr_data, f_rd_data, b_rd_data;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qmi_pkg::BK_ISSUE: begin
        if (op_valid) begin
          state_nxt = qmi_pkg::BK_COMPLETE;
        end
      end
      qmi_pkg::BK_COMPLETE: begin
        if (out_free) begin
          state_nxt = qmi_pkg::BK_ISSUE;
        end
      end
      default: state_nxt = qmi_pkg::BK_ISSUE;
    endcase
  end

  // outputs
  always_comb begin
    op_pop    = 1'b0;
    done      = 1'b0;
    f_rd_en   = 1'b0;
    b_rd_en   = 1'b0;
    b_wr_en   = 1'b0;
    f_wr_en   = 1'b0;
    f_wr_addr = op.f_wr_addr;
    f_wr_data = op.value;
    case (state_r)
      qmi_pkg::BK_ISSUE: begin
        op_pop  = op_valid;
        f_rd_en = op_valid && op.pop;
        b_rd_en = op_valid && op.move;
        b_wr_en = op_valid && op.b_wr;
        f_wr_en = op_valid && op.f_wr;
      end
      qmi_pkg::BK_COMPLETE: begin
        done      = out_free;
        f_wr_en   = out_free && op_r.move;
        f_wr_addr = op_r.f_wr_addr;
        f_wr_data = b_rd_data;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qmi_pkg::BK_ISSUE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      op_r <= op;
    end
    if (done) begin
      out_data_r.status       <= op_r.status;
      out_data_r.popped_value <= op_r.pop ? f_rd_data : '0;
      out_data_r.length       <= op_r.length;
    end
  end

  qmi_ram #(
    .WIDTH (qmi_pkg::VALW),
    .DEPTH (qmi_pkg::DEPTH)
  ) u_front_ring (
    .clk     (clk),
    .wr_en   (f_wr_en),
    .wr_addr (f_wr_addr),
    .wr_data (f_wr_data),
    .rd_en   (f_rd_en),
    .rd_addr (op.f_rd_addr),
    .rd_data (f_rd_data)
  );

  qmi_ram #(
    .WIDTH (qmi_pkg::VALW),
    .DEPTH (qmi_pkg::DEPTH)
  ) u_back_ring (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (op.b_wr_addr),
    .wr_data (op.value),
    .rd_en   (b_rd_en),
    .rd_addr (op.b_rd_addr),
    .rd_data (b_rd_data)
  );

endmodule

`default_nettype wire

[src/queue_with_middle_insert.sv]
// Top level of the bounded queue with push at tail, push at middle and pop at head.
//
//  channel  | ports                          | direction | transfer when
//  ---------+--------------------------------+-----------+-------------------------
//  input    | in_valid, in_stall, in_data    | in        | in_valid && !in_stall
//  result   | out_valid, out_stall, out_data | out       | out_valid && !out_stall
//
// The executor handles each item in an issue state that reads the needed
// half ring heads (registered RAM read) and a complete state that writes any
// entry moved between halves and loads the result register.
// The front end classifies an item in the cycle it is accepted; a 2-entry op
// queue lets it take up to two more items while the executor is busy.
// Reset (rst_n low, synchronous) clears starts, counts, queue and output
// valid; ring contents are never read before written, so no clearing pass.
// in_stall rises only when the op queue is full; out_stall holds the result.
`default_nettype none

module queue_with_middle_insert (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire qmi_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output qmi_pkg::out_item_t       out_data
);

  // classified op traffic
  logic         q_push, q_full, q_pop, q_valid;
  qmi_pkg::op_t q_in_op, q_head;

  // front end: bookkeeping of both half rings, decides every ring access up front
  qmi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_op     (q_in_op),
    .q_full   (q_full)
  );

  qmi_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  // back end: ring RAMs and the result register
  qmi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_valid),
    .op        (q_head),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------- checks

  // The executor only drains ops that are actually queued.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("op queue popped while empty");

  // Ops are not issued on consecutive cycles: each goes through the complete state.
  a_issue_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("op issued before previous op completed");

  // A half-to-half move only comes with a successful push or pop.
  a_move_status: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_in_op.move) |->
      (q_in_op.status == qmi_pkg::ST_PUSHED || q_in_op.status == qmi_pkg::ST_POPPED))
    else $error("ring move on a rejected item");

  // Only a real pop reports a value.
  a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != qmi_pkg::ST_POPPED) |-> (out_data.popped_value == '0))
    else $error("nonzero popped value on a non-pop result");

endmodule

`default_nettype wire

[test/tb_queue_with_middle_insert.sv]
// Self-checking testbench for queue_with_middle_insert: push tail/middle, pop, empty cases.
`timescale 1ns / 1ps

module tb_queue_with_middle_insert;

  // Generous limit: about 400 transfers, each with at worst a random input gap,
  // the issue and complete states and an output stall burst, taken many times over.
  localparam int CYCLE_LIMIT = 100000;
  localparam logic signed [qmi_pkg::VALW-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [qmi_pkg::VALW-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  qmi_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  qmi_pkg::out_item_t out_data;

  // Shadow copy of the queue contents, head at index 0, and the result
  // records still owed by the block, oldest first.
  logic signed [qmi_pkg::VALW-1:0] queue_shadow[$];
  qmi_pkg::out_item_t              owed_results[$];
  qmi_pkg::out_item_t              oldest_owed;

  logic idle_on = 1'b1;  // random gaps and stall bursts enabled
  int   stall_left = 0;
  int   cycle_count = 0;
  int   mismatches = 0;

  queue_with_middle_insert uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [qmi_pkg::VALW-1:0] want,
                                 input logic [qmi_pkg::VALW-1:0] got);
    mismatches++;
    $display("[%0t] mismatch %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Applies one accepted command to the shadow queue and records its result.
  // Middle insert lands at ceil(n/2); both pop codes pop, since the high
  // command bit selects pop.
  function automatic void apply_queue_command(input logic [qmi_pkg::CMDW-1:0] cmd,
                                              input logic signed [qmi_pkg::VALW-1:0] val);
    qmi_pkg::out_item_t res;
    int                 n;
    res = '0;
    n = queue_shadow.size();
    if (cmd == qmi_pkg::CMD_POP || cmd == qmi_pkg::CMD_POP_ALT) begin
      if (n == 0) begin
        res.status = qmi_pkg::ST_EMPTY;
      end else begin
        res.popped_value = queue_shadow.pop_front();
        res.status = qmi_pkg::ST_POPPED;
      end
    end else if (n >= qmi_pkg::DEPTH) begin
      res.status = qmi_pkg::ST_FULL;  // dropped, queue unchanged
    end else begin
      if (cmd == qmi_pkg::CMD_PUSH_TAIL) begin
        queue_shadow.push_back(val);
      end else begin
        queue_shadow.insert((n + 1) / 2, val);
      end
      res.status = qmi_pkg::ST_PUSHED;
    end
    res.length = qmi_pkg::LENW'(queue_shadow.size());
    owed_results.push_back(res);
  endfunction

  // Full-range random values half the time, with the extremes and a few
  // hand-picked patterns mixed in.
  function automatic logic signed [qmi_pkg::VALW-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd48;
      default: return $urandom;
    endcase
  endfunction

  // Drives one item and holds it until the transfer happens. A random gap
  // may come first; in_valid is only lowered on that path.
  task automatic send_item(input logic [qmi_pkg::CMDW-1:0] cmd,
                           input logic signed [qmi_pkg::VALW-1:0] val);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= qmi_pkg::in_item_t'({cmd, val});
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_queue_command(cmd, val);
  endtask

  // Sender holds off until every owed result has come back.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Result side: random stall bursts, result checking and the watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL queue_with_middle_insert");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result, status", '0, qmi_pkg::VALW'(out_data.status));
        end else begin
          oldest_owed = owed_results.pop_front();
          if (out_data.status !== oldest_owed.status) begin
            report_mismatch("status", qmi_pkg::VALW'(oldest_owed.status),
                            qmi_pkg::VALW'(out_data.status));
          end
          if (out_data.popped_value !== oldest_owed.popped_value) begin
            report_mismatch("popped_value", oldest_owed.popped_value, out_data.popped_value);
          end
          if (out_data.length !== oldest_owed.length) begin
            report_mismatch("length", qmi_pkg::VALW'(oldest_owed.length),
                            qmi_pkg::VALW'(out_data.length));
          end
        end
      end
      if (!idle_on) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 6);
        end
        out_stall <= (stall_left != 0);
        if (stall_left != 0) begin
          stall_left--;
        end
      end
    end
  end

  // Extremes of the value field, both pop codes, pops on empty, middle
  // insert into empty, odd and even lengths, and a popped 48.
  task automatic test_directed();
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP_ALT, VAL_MAX);
    send_item(qmi_pkg::CMD_PUSH_MID, VAL_MAX);
    send_item(qmi_pkg::CMD_PUSH_TAIL, VAL_MIN);
    send_item(qmi_pkg::CMD_PUSH_MID, 32'sd0);
    send_item(qmi_pkg::CMD_PUSH_MID, -32'sd1);
    send_item(qmi_pkg::CMD_PUSH_TAIL, 32'sd48);
    send_item(qmi_pkg::CMD_PUSH_MID, 32'sd1);
    send_item(qmi_pkg::CMD_PUSH_TAIL, 32'sh5555_5555);
    send_item(qmi_pkg::CMD_PUSH_MID, 32'shaaaa_aaaa);
    send_item(qmi_pkg::CMD_POP_ALT, 32'sd0);
    send_item(qmi_pkg::CMD_POP, -32'sd1);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_PUSH_MID, 32'sd48);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP_ALT, 32'sd0);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP, 32'sd0);
    send_item(qmi_pkg::CMD_POP_ALT, 32'sd0);
    wait_all_results();
  endtask

  // Grow to a few dozen entries, churn a little, then drain to empty and
  // pop once more.
  task automatic test_grow_and_drain();
    while (queue_shadow.size() < 30) begin
      send_item($urandom_range(0, 1) ? qmi_pkg::CMD_PUSH_MID : qmi_pkg::CMD_PUSH_TAIL,
                random_value());
    end
    wait_all_results();
    repeat (3) send_item(qmi_pkg::CMD_POP, random_value());
    repeat (3) send_item(qmi_pkg::CMD_PUSH_MID, random_value());
    send_item(qmi_pkg::CMD_PUSH_TAIL, random_value());
    while (queue_shadow.size() > 0) begin
      send_item($urandom_range(0, 3) == 0 ? qmi_pkg::CMD_POP_ALT : qmi_pkg::CMD_POP,
                random_value());
    end
    send_item(qmi_pkg::CMD_POP, random_value());
    wait_all_results();
  endtask

  // Random mix in phases of 50 items, each with its own push bias, so the
  // queue grows and shrinks and hits empty now and then.
  task automatic test_random_mix(input int count);
    int                       push_bias;
    logic [qmi_pkg::CMDW-1:0] cmd;
    push_bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        push_bias = $urandom_range(20, 85);
      end
      if ($urandom_range(0, 99) < push_bias) begin
        cmd = $urandom_range(0, 1) ? qmi_pkg::CMD_PUSH_MID : qmi_pkg::CMD_PUSH_TAIL;
      end else begin
        cmd = ($urandom_range(0, 3) == 0) ? qmi_pkg::CMD_POP_ALT : qmi_pkg::CMD_POP;
      end
      send_item(cmd, random_value());
    end
  endtask

  // Items offered back to back with no random gaps and no output stalls; in_stall still paces them.
  task automatic test_full_rate();
    idle_on <= 1'b0;
    @(posedge clk);
    test_random_mix(60);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_grow_and_drain();
    test_random_mix(250);
    wait_all_results();
    test_full_rate();

    // Final drain: a short tail after the last owed result catches stray results.
    wait_all_results();
    repeat (10) @(posedge clk);
    if (owed_results.size() != 0) begin
      report_mismatch("results never delivered", '0, qmi_pkg::VALW'(owed_results.size()));
    end
    if (mismatches == 0) begin
      $display("PASS queue_with_middle_insert");
    end else begin
      $display("FAIL queue_with_middle_insert");
    end
    $finish;
  end

endmodule
